// ----- rtl/ghsp_pkg.sv -----
// Package for the generational handle slot pool: sizes, codes and payload types.
// Depends on nothing; the top level and the checker refer to it by scoped names.
package ghsp_pkg;

    localparam int BLOCKS      = 16;
    localparam int BLOCK_SLOTS = 64;
    localparam int SLOTS       = BLOCKS * BLOCK_SLOTS;
    localparam int IDX_W       = 10;
    localparam int LINK_W      = 11;
    localparam int GEN_W       = 16;
    localparam int SYS_W       = 16;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

    typedef enum logic [1:0] {
        ACT_ALLOC    = 2'd0,
        ACT_FREE     = 2'd1,
        ACT_LOOKUP   = 2'd2,
        ACT_ALLOC_AT = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_NULL   = 3'd1,
        ST_SYSTEM = 3'd2,
        ST_STALE  = 3'd3,
        ST_EMPTY  = 3'd4,
        ST_BUSY   = 3'd5,
        ST_RANGE  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EVAL,
        S_FIX1,
        S_FIX2
    } state_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [SYS_W-1:0] handle_system;
        logic [IDX_W-1:0] handle_index;
        logic [GEN_W-1:0] handle_generation;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [IDX_W-1:0] slot_index;
        logic [GEN_W-1:0] slot_generation;
    } out_item_t;

    typedef struct packed {
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
        logic [GEN_W-1:0]  gen;
        logic              busy;
    } entry_t;

    // One pending neighbor patch: set next (or prev) of entry addr to val.
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  addr;
        logic              set_next;
        logic [LINK_W-1:0] val;
    } fix_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- rtl/ghsp_slot_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module ghsp_slot_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 39,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/generational_handle_slot_pool_top.sv -----
// Top level of the generational handle slot pool; uses ghsp_pkg and ghsp_slot_ram.
// Holds the request sequencer, the free-list head and the result register.
//
// The pool keeps 1024 slots, each with a next link, a prev link, a 16-bit
// generation and a busy bit, all in one synchronous RAM with one write port
// and one read port. After reset the block runs an initialization pass that
// writes every entry (list in index order, generation 1, free); in_ready
// stays low during that pass, while configuration writes are taken as usual.
// Requests are handled one at a time. A lookup, a failed request or an alloc
// from an empty pool passes through S_EVAL only; an alloc or free may also
// pass through S_FIX1, and an alloc_at through S_FIX1, S_FIX2 or both, since
// it patches both neighbors of the slot it removes, and each patch is a
// read-modify-write through the RAM ports. The result register is loaded in
// S_EVAL and holds the result until taken; a new request is taken only when
// the result register will be free for it.
module generational_handle_slot_pool_top (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  ghsp_pkg::in_item_t       in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output ghsp_pkg::out_item_t      out_data,
    input  logic                     cfg_we,
    input  logic [ghsp_pkg::SYS_W-1:0] cfg_data
);

    ghsp_pkg::state_t                   state_reg, state_next;
    logic [ghsp_pkg::LINK_W-1:0]        init_cnt_reg, init_cnt_next;
    logic [ghsp_pkg::LINK_W-1:0]        head_reg, head_next;
    logic [ghsp_pkg::SYS_W-1:0]         system_id_reg;
    ghsp_pkg::in_item_t                 req_reg;
    ghsp_pkg::fix_t                     fix1_reg, fix2_reg, fix1_next, fix2_next;
    logic                               out_valid_reg, out_valid_next;
    ghsp_pkg::out_item_t                out_data_reg, res;

    logic                               ram_we, ram_re;
    logic [ghsp_pkg::IDX_W-1:0]         ram_waddr, ram_raddr;
    ghsp_pkg::entry_t                   ram_wdata, q;
    logic [ghsp_pkg::ENTRY_W-1:0]       ram_rdata;

    logic                               in_fire;
    logic                               in_range;
    logic [ghsp_pkg::GEN_W-1:0]         cur_gen, gen_inc;
    logic [ghsp_pkg::IDX_W-1:0]         init_idx;

    ghsp_slot_ram #(
        .DEPTH (ghsp_pkg::SLOTS),
        .WIDTH (ghsp_pkg::ENTRY_W),
        .ADDR_W(ghsp_pkg::IDX_W)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign q         = ghsp_pkg::entry_t'(ram_rdata);
    assign in_ready  = (state_reg == ghsp_pkg::S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign init_idx  = init_cnt_reg[ghsp_pkg::IDX_W-1:0];

    // Request decode against the entry read in the acceptance cycle.
    assign in_range = {1'b0, req_reg.handle_index} < ghsp_pkg::NIL;
    assign cur_gen  = in_range ? q.gen : '0;
    assign gen_inc  = (q.gen + 16'd1 == '0) ? 16'd1 : q.gen + 16'd1;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ghsp_pkg::S_INIT:
                if (init_cnt_reg == ghsp_pkg::NIL - 11'd1)
                    state_next = ghsp_pkg::S_IDLE;
            ghsp_pkg::S_IDLE:
                if (in_fire)
                    state_next = ghsp_pkg::S_EVAL;
            ghsp_pkg::S_EVAL:
                if (fix1_next.valid)
                    state_next = ghsp_pkg::S_FIX1;
                else if (fix2_next.valid)
                    state_next = ghsp_pkg::S_FIX2;
                else
                    state_next = ghsp_pkg::S_IDLE;
            ghsp_pkg::S_FIX1:
                if (fix2_reg.valid)
                    state_next = ghsp_pkg::S_FIX2;
                else
                    state_next = ghsp_pkg::S_IDLE;
            ghsp_pkg::S_FIX2:
                state_next = ghsp_pkg::S_IDLE;
            default:
                state_next = ghsp_pkg::S_INIT;
        endcase
    end

    // Datapath and RAM control for each state.
    always_comb
    begin
        init_cnt_next  = init_cnt_reg;
        head_next      = head_reg;
        fix1_next      = fix1_reg;
        fix2_next      = fix2_reg;
        res            = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        unique case (state_reg)
            ghsp_pkg::S_INIT:
            begin
                // Build the index-ordered free list.
                ram_we         = 1'b1;
                ram_waddr      = init_idx;
                ram_wdata.next = init_cnt_reg + 11'd1;
                ram_wdata.prev = (init_cnt_reg == '0) ? ghsp_pkg::NIL : init_cnt_reg - 11'd1;
                ram_wdata.gen  = 16'd1;
                ram_wdata.busy = 1'b0;
                init_cnt_next  = init_cnt_reg + 11'd1;
            end
            ghsp_pkg::S_IDLE:
            begin
                ram_re    = in_fire;
                ram_raddr = (in_data.action == ghsp_pkg::ACT_ALLOC)
                            ? head_reg[ghsp_pkg::IDX_W-1:0] : in_data.handle_index;
            end
            ghsp_pkg::S_EVAL:
            begin
                fix1_next      = '0;
                fix2_next      = '0;
                out_valid_next = 1'b1;
                res.slot_index      = req_reg.handle_index;
                res.slot_generation = cur_gen;
                res.status          = ghsp_pkg::ST_OK;
                unique case (req_reg.action)
                    ghsp_pkg::ACT_ALLOC:
                    begin
                        if (head_reg == ghsp_pkg::NIL)
                        begin
                            res.status          = ghsp_pkg::ST_EMPTY;
                            res.slot_index      = '0;
                            res.slot_generation = '0;
                        end
                        else
                        begin
                            res.slot_index      = head_reg[ghsp_pkg::IDX_W-1:0];
                            res.slot_generation = q.gen;
                            ram_we         = 1'b1;
                            ram_waddr      = head_reg[ghsp_pkg::IDX_W-1:0];
                            ram_wdata.next = ghsp_pkg::NIL;
                            ram_wdata.prev = ghsp_pkg::NIL;
                            ram_wdata.gen  = q.gen;
                            ram_wdata.busy = 1'b1;
                            head_next      = q.next;
                            fix1_next.valid    = (q.next != ghsp_pkg::NIL);
                            fix1_next.addr     = q.next[ghsp_pkg::IDX_W-1:0];
                            fix1_next.set_next = 1'b0;
                            fix1_next.val      = ghsp_pkg::NIL;
                        end
                    end
                    ghsp_pkg::ACT_FREE:
                    begin
                        if (!in_range)
                        begin
                            res.status = ghsp_pkg::ST_RANGE;
                        end
                        else if (!q.busy)
                        begin
                            res.status = ghsp_pkg::ST_STALE;
                        end
                        else
                        begin
                            res.slot_generation = gen_inc;
                            ram_we         = 1'b1;
                            ram_waddr      = req_reg.handle_index;
                            ram_wdata.next = head_reg;
                            ram_wdata.prev = ghsp_pkg::NIL;
                            ram_wdata.gen  = gen_inc;
                            ram_wdata.busy = 1'b0;
                            head_next      = {1'b0, req_reg.handle_index};
                            fix1_next.valid    = (head_reg != ghsp_pkg::NIL);
                            fix1_next.addr     = head_reg[ghsp_pkg::IDX_W-1:0];
                            fix1_next.set_next = 1'b0;
                            fix1_next.val      = {1'b0, req_reg.handle_index};
                        end
                    end
                    default:
                    begin
                        if (req_reg.handle_generation == '0)
                            res.status = ghsp_pkg::ST_NULL;
                        else if (req_reg.handle_system != system_id_reg)
                            res.status = ghsp_pkg::ST_SYSTEM;
                        else if (!in_range)
                            res.status = ghsp_pkg::ST_RANGE;
                        else if (req_reg.action == ghsp_pkg::ACT_LOOKUP)
                        begin
                            if (req_reg.handle_generation != cur_gen)
                                res.status = ghsp_pkg::ST_STALE;
                        end
                        else if (q.busy)
                            res.status = ghsp_pkg::ST_BUSY;
                        else
                        begin
                            // Take the named slot out of the free list, wherever it sits in it.
                            res.slot_generation = req_reg.handle_generation;
                            ram_we         = 1'b1;
                            ram_waddr      = req_reg.handle_index;
                            ram_wdata.next = ghsp_pkg::NIL;
                            ram_wdata.prev = ghsp_pkg::NIL;
                            ram_wdata.gen  = req_reg.handle_generation;
                            ram_wdata.busy = 1'b1;
                            if (q.prev == ghsp_pkg::NIL)
                                head_next = q.next;
                            fix1_next.valid    = (q.prev != ghsp_pkg::NIL);
                            fix1_next.addr     = q.prev[ghsp_pkg::IDX_W-1:0];
                            fix1_next.set_next = 1'b1;
                            fix1_next.val      = q.next;
                            fix2_next.valid    = (q.next != ghsp_pkg::NIL);
                            fix2_next.addr     = q.next[ghsp_pkg::IDX_W-1:0];
                            fix2_next.set_next = 1'b0;
                            fix2_next.val      = q.prev;
                        end
                    end
                endcase
                ram_re    = fix1_next.valid || fix2_next.valid;
                ram_raddr = fix1_next.valid ? fix1_next.addr : fix2_next.addr;
            end
            ghsp_pkg::S_FIX1:
            begin
                ram_we    = 1'b1;
                ram_waddr = fix1_reg.addr;
                ram_wdata = q;
                if (fix1_reg.set_next)
                    ram_wdata.next = fix1_reg.val;
                else
                    ram_wdata.prev = fix1_reg.val;
                ram_re    = fix2_reg.valid;
                ram_raddr = fix2_reg.addr;
            end
            ghsp_pkg::S_FIX2:
            begin
                ram_we    = 1'b1;
                ram_waddr = fix2_reg.addr;
                ram_wdata = q;
                if (fix2_reg.set_next)
                    ram_wdata.next = fix2_reg.val;
                else
                    ram_wdata.prev = fix2_reg.val;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ghsp_pkg::S_INIT;
            init_cnt_reg  <= '0;
            head_reg      <= '0;
            system_id_reg <= '0;
            out_valid_reg <= 1'b0;
            fix1_reg      <= '0;
            fix2_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
            fix1_reg      <= fix1_next;
            fix2_reg      <= fix2_next;
            if (cfg_we)
                system_id_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            req_reg <= in_data;
        out_data_reg <= res;
    end

endmodule

// ----- rtl/ghsp_checker.sv -----
// Port-level checker for the slot pool, bound to the top level.
// Depends on ghsp_pkg and generational_handle_slot_pool_top.
module ghsp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input ghsp_pkg::out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while one is in work");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("no result two cycles after request transfer");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= ghsp_pkg::ST_RANGE)
        else $error("undefined status code");

endmodule

bind generational_handle_slot_pool_top ghsp_checker u_ghsp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
);
